/* design/atk_pkg.sv */
package atk_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // character classes; the pending state only ever holds the first five
   typedef enum logic [2:0] {
      CL_SPACE = 3'd0,
      CL_NUM   = 3'd1,
      CL_OPR   = 3'd2,
      CL_OPEN  = 3'd3,
      CL_CLOSE = 3'd4,
      CL_END   = 3'd5,
      CL_BAD   = 3'd6
   } class_type;

   typedef enum logic [2:0] {
      TK_OPERAND  = 3'd0,
      TK_OPERATOR = 3'd1,
      TK_OPEN     = 3'd2,
      TK_CLOSE    = 3'd3,
      TK_END      = 3'd4,
      TK_INVALID  = 3'd5
   } token_type;

   // tokens caused by one character: a flushed pending token, then end or invalid
   typedef struct packed {
      logic        has0;
      token_type   kind0;
      logic [30:0] num0;
      logic [7:0]  sym0;
      logic        has1;
      token_type   kind1;
   } rec_type;

   function automatic class_type classify(input logic [7:0] c);
      class_type cls;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         cls = CL_NUM;
      end else begin
         case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: cls = CL_OPR;
            CH_OPEN:  cls = CL_OPEN;
            CH_CLOSE: cls = CL_CLOSE;
            CH_SPACE: cls = CL_SPACE;
            CH_NUL:   cls = CL_END;
            default:  cls = CL_BAD;
         endcase
      end
      return cls;
   endfunction

endpackage

/* design/atk_front.sv */
module atk_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_in,
   output logic              rec_push,
   output atk_pkg::rec_type  rec
);

   atk_pkg::class_type pend_ff, pend_in;
   logic [30:0]        accum_ff, accum_in;
   logic [7:0]         prev_ff, prev_in;

   atk_pkg::class_type cls;
   logic [3:0]         digit;
   logic [34:0]        prod;
   logic [30:0]        accum_sat;
   logic               extend;
   logic               pend_sym;
   logic               cls_sym;
   logic               finish;

   assign cls      = atk_pkg::classify(char_in);
   assign digit    = 4'(char_in - atk_pkg::CH_ZERO);
   assign extend   = (pend_ff == atk_pkg::CL_NUM) && (cls == atk_pkg::CL_NUM);
   assign finish   = (cls == atk_pkg::CL_END) || (cls == atk_pkg::CL_BAD);
   assign pend_sym = (pend_ff == atk_pkg::CL_OPR) || (pend_ff == atk_pkg::CL_OPEN) ||
                     (pend_ff == atk_pkg::CL_CLOSE);
   assign cls_sym  = (cls == atk_pkg::CL_OPR) || (cls == atk_pkg::CL_OPEN) ||
                     (cls == atk_pkg::CL_CLOSE);

   // accum * 10 + digit, saturated
   assign prod      = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + 35'(digit);
   assign accum_sat = (prod > 35'(atk_pkg::NUM_MAX)) ? atk_pkg::NUM_MAX : prod[30:0];

   // next state
   always_comb begin
      pend_in  = pend_ff;
      accum_in = accum_ff;
      prev_in  = prev_ff;
      if (accept) begin
         if (extend) begin
            accum_in = accum_sat;
         end else if (finish) begin
            pend_in  = atk_pkg::CL_SPACE;
            accum_in = '0;
            prev_in  = '0;
         end else begin
            pend_in  = cls;
            accum_in = (cls == atk_pkg::CL_NUM) ? 31'(digit) : '0;
            prev_in  = cls_sym ? char_in : '0;
         end
      end
   end

   // outputs
   always_comb begin
      rec       = '0;
      rec.has0  = !extend && ((pend_ff == atk_pkg::CL_NUM) || pend_sym);
      rec.kind0 = atk_pkg::TK_OPERAND;
      unique case (pend_ff)
         atk_pkg::CL_NUM:   rec.kind0 = atk_pkg::TK_OPERAND;
         atk_pkg::CL_OPR:   rec.kind0 = atk_pkg::TK_OPERATOR;
         atk_pkg::CL_OPEN:  rec.kind0 = atk_pkg::TK_OPEN;
         atk_pkg::CL_CLOSE: rec.kind0 = atk_pkg::TK_CLOSE;
         default:           rec.kind0 = atk_pkg::TK_OPERAND;
      endcase
      rec.num0  = (pend_ff == atk_pkg::CL_NUM) ? accum_ff : '0;
      rec.sym0  = pend_sym ? prev_ff : '0;
      rec.has1  = finish;
      rec.kind1 = (cls == atk_pkg::CL_END) ? atk_pkg::TK_END : atk_pkg::TK_INVALID;
      rec_push  = accept && (rec.has0 || rec.has1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= atk_pkg::CL_SPACE;
         accum_ff <= '0;
         prev_ff  <= '0;
      end else begin
         pend_ff  <= pend_in;
         accum_ff <= accum_in;
         prev_ff  <= prev_in;
      end
   end

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      accept && finish |=> pend_ff == atk_pkg::CL_SPACE && accum_ff == '0)
      else $error("state not cleared after end or invalid");

   a_num_no_sym: assert property (@(posedge clock) disable iff (reset)
      pend_ff == atk_pkg::CL_NUM |-> prev_ff == '0)
      else $error("symbol held during digit run");

endmodule

/* design/atk_queue.sv */
module atk_queue #(
   parameter int Depth = atk_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  atk_pkg::rec_type  wdata,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output atk_pkg::rec_type  rdata
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   atk_pkg::rec_type mem [Depth];
   logic [PtrW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign rdata = mem[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

/* design/atk_back.sv */
module atk_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  atk_pkg::rec_type  q_rec,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [2:0]        rsp_token_kind,
   output logic [30:0]       rsp_number_value,
   output logic [7:0]        rsp_symbol_char,
   output logic              rsp_run_last
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   logic [2:0]  kind_ff, kind_in;
   logic [30:0] num_ff, num_in;
   logic [7:0]  sym_ff, sym_in;
   logic        last_ff, last_in;

   logic load;
   logic first;

   assign load  = !q_empty && (!valid_ff || rsp_pop);
   assign first = q_rec.has0 && !phase_ff;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      num_in   = num_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (rsp_pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (first) begin
            kind_in  = q_rec.kind0;
            num_in   = q_rec.num0;
            sym_in   = q_rec.sym0;
            last_in  = !q_rec.has1;
            phase_in = q_rec.has1;
            q_pop    = !q_rec.has1;
         end else begin
            kind_in  = q_rec.kind1;
            num_in   = '0;
            sym_in   = '0;
            last_in  = 1'b1;
            phase_in = 1'b0;
            q_pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      num_ff  <= num_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_number_value = num_ff;
   assign rsp_symbol_char  = sym_ff;
   assign rsp_run_last     = last_ff;

   a_phase_has_rec: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !q_empty && q_rec.has1)
      else $error("second token pending without a record");

endmodule

/* design/arith_expr_tokenizer.sv */
// Arithmetic expression tokenizer. One character is taken per transfer on the
// req_ side and sorted into digit, operator (+ - * / %), bracket, space, zero
// terminator or invalid. Digit runs build a decimal operand that saturates at
// 2^31-1; any character but a digit that extends a number flushes the pending
// token, and a terminator or an invalid character flushes it and then gives an
// end or invalid token, after which the tokenizer starts afresh. A character is
// accepted every cycle while the internal token queue (QueueDepth records) has
// room; the rsp_ side gives at most one token per cycle from its output
// register, so a character that causes two tokens gives them one after the
// other, and the queue absorbs such bursts.
module arith_expr_tokenizer #(
   parameter int QueueDepth = atk_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_in,
   // token output
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_token_kind,
   output logic [30:0] rsp_number_value,
   output logic [7:0]  rsp_symbol_char,
   output logic        rsp_run_last
);

   logic             accept;
   logic             rec_push;
   atk_pkg::rec_type rec_w;
   atk_pkg::rec_type rec_r;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   // input transfer; stalls only when the token queue is full
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: classify and track the pending token
   atk_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .char_in  (req_char_in),
      .rec_push (rec_push),
      .rec      (rec_w)
   );

   // decoupling queue, one record per character that causes tokens
   atk_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (rec_push),
      .wdata (rec_w),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .rdata (rec_r)
   );

   // back: serialize one or two tokens per record into the output register
   atk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_rec            (rec_r),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_number_value (rsp_number_value),
      .rsp_symbol_char  (rsp_symbol_char),
      .rsp_run_last     (rsp_run_last)
   );

endmodule
